>>> src/pshc_pkg.sv
// ---------------------------------------------------------------------------
// pshc_pkg
// shared types and constants for the plant sensor hysteresis controller
// ---------------------------------------------------------------------------
package pshc_pkg;

	localparam int NUM_CH = 3;
	localparam int SAMPLE_W = 12;
	localparam int SUM_W = 16;
	localparam int PCT_W = 7;
	localparam int TEMP_W = 12;

	localparam logic [1:0] REG_PUMP_ON = 2'd0;
	localparam logic [1:0] REG_PUMP_OFF = 2'd1;
	localparam logic [1:0] REG_LAMP_ON = 2'd2;
	localparam logic [1:0] REG_LAMP_OFF = 2'd3;

	localparam logic [11:0] HUM_MAX = 12'd3700;
	localparam logic [11:0] HUM_MIN = 12'd3300;
	localparam logic [11:0] LIT_MAX = 12'd2700;
	localparam logic [11:0] LIT_MIN = 12'd300;
	localparam logic [10:0] TEMP_SCALE = 11'd1320;
	localparam logic [21:0] TEMP_OFFSET = 22'd1142505; // 279 * 4095
	localparam logic [12:0] TEMP_DIV = 13'd4095;

	// lane request: window average finished
	typedef struct packed {
		logic done;
		logic [SAMPLE_W-1:0] avg;
	} lane_res_t;

endpackage

>>> src/pshc_lane.sv
// ---------------------------------------------------------------------------
// pshc_lane
// one channel: sliding window, running sum and bit-serial average divider
// ---------------------------------------------------------------------------
module pshc_lane import pshc_pkg::*; #(
	parameter int WINDOW = 10
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [SAMPLE_W-1:0] sample,
	output lane_res_t res
);
	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);

	logic [SAMPLE_W-1:0] win_q [WINDOW];
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] slot_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] div_q;
	logic [4:0] bit_q;
	logic busy_q;
	logic done_q;

	logic full;
	logic [SUM_W-1:0] new_sum;
	logic [SUM_W:0] trial;
	logic [SUM_W-1:0] rem_sh;

	assign full = (fill_q == CNT_W'(WINDOW));
	always_comb begin
		if (full)
			new_sum = sum_q - SUM_W'(win_q[slot_q]) + SUM_W'(sample);
		else
			new_sum = sum_q + SUM_W'(sample);
	end

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q[SUM_W-2:0], quo_q[SUM_W-1]};
	assign trial = {1'b0, rem_sh} - (SUM_W+1)'(div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			slot_q <= '0;
			sum_q <= '0;
			div_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				sum_q <= new_sum;
				if (full) begin
					slot_q <= (slot_q == IDX_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					div_q <= CNT_W'(WINDOW);
				end else begin
					fill_q <= fill_q + 1'b1;
					div_q <= fill_q + 1'b1;
				end
				busy_q <= 1'b1;
				bit_q <= 5'(SUM_W);
			end else if (busy_q) begin
				bit_q <= bit_q - 1'b1;
				if (bit_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (full)
				win_q[slot_q] <= sample;
			else
				win_q[fill_q[IDX_W-1:0]] <= sample;
			rem_q <= '0;
			quo_q <= new_sum;
		end else if (busy_q) begin
			if (trial[SUM_W]) begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end else begin
				rem_q <= trial[SUM_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end
		end
	end

	assign res.done = done_q;
	assign res.avg = quo_q[SAMPLE_W-1:0];
endmodule

>>> src/pshc_merge.sv
// ---------------------------------------------------------------------------
// pshc_merge
// calibration of the three averages and the pump and lamp hysteresis
// ---------------------------------------------------------------------------
module pshc_merge import pshc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [SAMPLE_W-1:0] havg,
	input logic [SAMPLE_W-1:0] lavg,
	input logic [SAMPLE_W-1:0] tavg,
	input logic force_pump,
	input logic auto_pump,
	input logic force_lamp,
	input logic [PCT_W-1:0] pump_on_lvl,
	input logic [PCT_W-1:0] pump_off_lvl,
	input logic [PCT_W-1:0] lamp_on_lvl,
	input logic [PCT_W-1:0] lamp_off_lvl,
	output logic done,
	output logic pump_on,
	output logic lamp_on,
	output logic [PCT_W-1:0] hpct,
	output logic [PCT_W-1:0] lpct,
	output logic signed [TEMP_W-1:0] temp
);
	// step 1: clamp and multiply
	logic [11:0] hc, lc;
	logic [15:0] hm_s1;
	logic [17:0] lm_s1;
	logic signed [23:0] tm_s1;
	logic v1_s1, v2_s2, v3_s3;
	logic fp_s1, ap_s1, fl_s1;

	always_comb begin
		hc = (havg < HUM_MIN) ? HUM_MIN : (havg > HUM_MAX) ? HUM_MAX : havg;
		lc = (lavg < LIT_MIN) ? LIT_MIN : (lavg > LIT_MAX) ? LIT_MAX : lavg;
	end

	// step 2: divide by 400 / 2400 via reciprocal, temperature by 4095
	logic [PCT_W-1:0] hp_s2, lp_s2;
	logic [35:0] hr, lr;
	logic signed [23:0] tq_s2;
	logic [23:0] tabs;
	logic [36:0] tprod;
	logic [12:0] tquo;
	logic [24:0] tchk;

	assign hr = 36'(hm_s1) * 36'd10486;          // /400 ~ *10486>>22
	assign lr = 36'(lm_s1) * 36'd13982;          // /2400 ~ *13982>>25
	assign tabs = tm_s1[23] ? 24'(-tm_s1) : 24'(tm_s1);
	assign tprod = 37'(tabs) * 37'd4097;          // /4095 ~ *4097>>24
	always_comb begin
		tquo = tprod[36:24];
		tchk = 25'(tquo) * 25'(TEMP_DIV);
		if (25'(tabs) >= tchk + 25'(TEMP_DIV)) tquo = tquo + 1'b1;
	end

	logic fp_s2, ap_s2, fl_s2;
	logic [PCT_W-1:0] hpx, lpx;
	always_comb begin
		hpx = hr[28:22];
		if (36'(hm_s1) >= (36'(hpx) + 36'd1) * 36'd400) hpx = hpx + 1'b1;
		lpx = lr[31:25];
		if (36'(lm_s1) >= (36'(lpx) + 36'd1) * 36'd2400) lpx = lpx + 1'b1;
	end

	logic pump_flag_q, lamp_flag_q;
	logic pd, pf, ld, lf;
	always_comb begin
		pf = pump_flag_q;
		pd = 1'b0;
		if (pump_flag_q || hp_s2 <= pump_on_lvl) begin
			pf = 1'b1; pd = 1'b1;
			if (hp_s2 >= pump_off_lvl) begin
				pf = 1'b0; pd = 1'b0;
			end
		end else
			pf = 1'b0;
		lf = lamp_flag_q;
		ld = 1'b0;
		if (lamp_flag_q || lp_s2 <= lamp_on_lvl) begin
			lf = 1'b1; ld = 1'b1;
			if (lp_s2 >= lamp_off_lvl) begin
				lf = 1'b0; ld = 1'b0;
			end
		end else
			lf = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			pump_flag_q <= 1'b0;
			lamp_flag_q <= 1'b0;
		end else begin
			v1_s1 <= start;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			if (v2_s2) begin
				if (!fp_s2 && ap_s2) pump_flag_q <= pf;
				if (!fl_s2) lamp_flag_q <= lf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hm_s1 <= 16'(HUM_MAX - hc) * 16'd100;
			lm_s1 <= 18'(LIT_MAX - lc) * 18'd100;
			tm_s1 <= $signed(24'(tavg) * 24'(TEMP_SCALE)) - $signed(24'(TEMP_OFFSET));
			fp_s1 <= force_pump;
			ap_s1 <= auto_pump;
			fl_s1 <= force_lamp;
		end
		if (v1_s1) begin
			hp_s2 <= hpx;
			lp_s2 <= lpx;
			tq_s2 <= tm_s1[23] ? -$signed(24'(tquo)) : $signed(24'(tquo));
			fp_s2 <= fp_s1;
			ap_s2 <= ap_s1;
			fl_s2 <= fl_s1;
		end
		if (v2_s2) begin
			pump_on <= fp_s2 ? 1'b1 : (ap_s2 ? pd : 1'b0);
			lamp_on <= fl_s2 ? 1'b1 : ld;
			hpct <= hp_s2;
			lpct <= lp_s2;
			temp <= tq_s2[TEMP_W-1:0];
		end
	end

	assign done = v3_s3;
endmodule

>>> src/plant_sensor_hysteresis_controller_unit.sv
// ---------------------------------------------------------------------------
// plant_sensor_hysteresis_controller_unit
// three averaging lanes feeding calibration and hysteresis pump/lamp control
// ---------------------------------------------------------------------------
// channel  dir  contents
// s_axis   in   scan request: three samples and switches
// m_axis   out  result request: drive flags, percents, temperature
// cfg      in   hysteresis levels, index 0..3
//
// m_axis_tvalid rises once an accepted scan has passed the bit-serial
// average divider in each lane, running in parallel, three calibration
// stages, then the output register
// one scan is in flight at a time; s_axis_tready is low until the result
// request has been taken on m_axis
// arst_n clears windows' fill counts, sums, flags and levels to defaults
module plant_sensor_hysteresis_controller_unit import pshc_pkg::*; #(
	parameter int WINDOW = 10
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// humidity[11:0], light[23:12], temperature[35:24], force_pump[36],
	// auto_pump[37], force_lamp[38], zero[39]
	input logic [39:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// pump_on[0], lamp_on[1], auto_indicator[2], humidity_percent[9:3],
	// light_percent[16:10], temperature_value[28:17], zero[31:29]
	output logic [31:0] m_axis_tdata,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [6:0] cfg_data
);
	logic busy_q, accept, out_v_q;
	logic [PCT_W-1:0] pon_q, poff_q, lon_q, loff_q;
	logic fp_q, ap_q, fl_q;
	lane_res_t hres, lres, tres;
	logic mdone, pump, lamp;
	logic [PCT_W-1:0] hp, lp;
	logic signed [TEMP_W-1:0] tv;

	assign s_axis_tready = !busy_q;
	assign accept = s_axis_tvalid && s_axis_tready;

	pshc_lane #(.WINDOW(WINDOW)) u_hum (.clk, .arst_n, .start(accept),
		.sample(s_axis_tdata[11:0]), .res(hres));
	pshc_lane #(.WINDOW(WINDOW)) u_lit (.clk, .arst_n, .start(accept),
		.sample(s_axis_tdata[23:12]), .res(lres));
	pshc_lane #(.WINDOW(WINDOW)) u_tmp (.clk, .arst_n, .start(accept),
		.sample(s_axis_tdata[35:24]), .res(tres));

	pshc_merge u_merge (.clk, .arst_n, .start(hres.done && lres.done && tres.done),
		.havg(hres.avg), .lavg(lres.avg), .tavg(tres.avg),
		.force_pump(fp_q), .auto_pump(ap_q), .force_lamp(fl_q),
		.pump_on_lvl(pon_q), .pump_off_lvl(poff_q),
		.lamp_on_lvl(lon_q), .lamp_off_lvl(loff_q),
		.done(mdone), .pump_on(pump), .lamp_on(lamp),
		.hpct(hp), .lpct(lp), .temp(tv));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_v_q <= 1'b0;
			pon_q <= 7'd30;
			poff_q <= 7'd70;
			lon_q <= 7'd35;
			loff_q <= 7'd45;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PUMP_ON: pon_q <= cfg_data;
					REG_PUMP_OFF: poff_q <= cfg_data;
					REG_LAMP_ON: lon_q <= cfg_data;
					REG_LAMP_OFF: loff_q <= cfg_data;
				endcase
			end
			if (accept) busy_q <= 1'b1;
			if (mdone) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_v_q <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fp_q <= s_axis_tdata[36];
			ap_q <= s_axis_tdata[37];
			fl_q <= s_axis_tdata[38];
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {3'b000, tv, lp, hp, ap_q, lamp, pump};
endmodule

>>> verif/plant_sensor_hysteresis_controller_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// plant_sensor_hysteresis_controller_unit_tb
// drives scan requests with random idling on both sides, predicts each result
// request from the window averages, calibration and hysteresis, and checks it
// ---------------------------------------------------------------------------

class pshc_scoreboard;
	logic [11:0] hum_win[10], lit_win[10], tmp_win[10];
	int unsigned fill[3], oldest[3];
	logic [15:0] wsum[3];
	bit pump_flag, lamp_flag;
	int unsigned lvl[4];
	logic [31:0] pending[$];
	int errors;

	function void clear();
		for (int c = 0; c < 3; c++) begin
			fill[c] = 0;
			oldest[c] = 0;
			wsum[c] = '0;
		end
		pump_flag = 0;
		lamp_flag = 0;
		lvl[pshc_pkg::REG_PUMP_ON] = 30;
		lvl[pshc_pkg::REG_PUMP_OFF] = 70;
		lvl[pshc_pkg::REG_LAMP_ON] = 35;
		lvl[pshc_pkg::REG_LAMP_OFF] = 45;
		pending.delete();
		errors = 0;
	endfunction

	function int unsigned push_avg(int c, int unsigned s);
		int unsigned sl, old;
		if (fill[c] < 10) begin
			if (c == 0) hum_win[fill[c]] = s;
			else if (c == 1) lit_win[fill[c]] = s;
			else tmp_win[fill[c]] = s;
			fill[c]++;
			wsum[c] = wsum[c] + s;
			return wsum[c] / fill[c];
		end
		sl = oldest[c];
		old = (c == 0) ? hum_win[sl] : (c == 1) ? lit_win[sl] : tmp_win[sl];
		wsum[c] = wsum[c] - old + s;
		if (c == 0) hum_win[sl] = s;
		else if (c == 1) lit_win[sl] = s;
		else tmp_win[sl] = s;
		oldest[c] = (sl + 1 == 10) ? 0 : sl + 1;
		return wsum[c] / 10;
	endfunction

	function bit hyst(ref bit flag, input int unsigned v, int unsigned on_l, int unsigned off_l);
		if (flag || v <= on_l) begin
			flag = 1;
			if (v >= off_l) begin
				flag = 0;
				return 0;
			end
			return 1;
		end
		flag = 0;
		return 0;
	endfunction

	function void note_scan(logic [39:0] d);
		int unsigned ha, la, ta, hp, lp;
		int t;
		bit pump, lamp;
		logic [11:0] tv;
		ha = push_avg(0, d[11:0]);
		la = push_avg(1, d[23:12]);
		ta = push_avg(2, d[35:24]);
		if (ha < 3300) ha = 3300;
		if (ha > 3700) ha = 3700;
		hp = (3700 - ha) * 100 / 400;
		if (la < 300) la = 300;
		if (la > 2700) la = 2700;
		lp = (2700 - la) * 100 / 2400;
		t = (int'(ta) * 1320 - 279 * 4095) / 4095;
		tv = t[11:0];
		if (d[36]) pump = 1;
		else if (d[37])
			pump = hyst(pump_flag, hp, lvl[pshc_pkg::REG_PUMP_ON], lvl[pshc_pkg::REG_PUMP_OFF]);
		else pump = 0;
		if (d[38]) lamp = 1;
		else lamp = hyst(lamp_flag, lp, lvl[pshc_pkg::REG_LAMP_ON], lvl[pshc_pkg::REG_LAMP_OFF]);
		pending.push_back({3'b0, tv, lp[6:0], hp[6:0], d[37], lamp, pump});
	endfunction

	function void check_result(logic [31:0] got);
		logic [31:0] e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got[0] !== e[0]) begin
			$display("%0t: pump_on exp %b got %b", $time, e[0], got[0]);
			errors++;
		end
		if (got[1] !== e[1]) begin
			$display("%0t: lamp_on exp %b got %b", $time, e[1], got[1]);
			errors++;
		end
		if (got[2] !== e[2]) begin
			$display("%0t: auto_indicator exp %b got %b", $time, e[2], got[2]);
			errors++;
		end
		if (got[9:3] !== e[9:3]) begin
			$display("%0t: humidity_percent exp %0d got %0d", $time, e[9:3], got[9:3]);
			errors++;
		end
		if (got[16:10] !== e[16:10]) begin
			$display("%0t: light_percent exp %0d got %0d", $time, e[16:10], got[16:10]);
			errors++;
		end
		if (got[28:17] !== e[28:17]) begin
			$display("%0t: temperature_value exp %0d got %0d", $time,
				$signed(e[28:17]), $signed(got[28:17]));
			errors++;
		end
	endfunction
endclass

module plant_sensor_hysteresis_controller_unit_tb;
	import pshc_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;

	pshc_scoreboard board;
	bit quiet_tail;
	int idle_cycles;
	int rdy_hold;

	plant_sensor_hysteresis_controller_unit u_top (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		m_axis_tready = 0;
		cfg_we = 0;
		cfg_index = REG_PUMP_ON;
		cfg_data = '0;
		quiet_tail = 0;
		board = new();
		board.clear();
	end

	// result side: random stall bursts, checks on each accepted request
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
			if (rdy_hold != 0) begin
				m_axis_tready <= 0;
				rdy_hold <= rdy_hold - 1;
			end else if (!quiet_tail && m_axis_tready && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 0;
				rdy_hold <= $urandom_range(0, 3);
			end else
				m_axis_tready <= 1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[plant_sensor_hysteresis_controller_unit] ERROR");
			$finish;
		end
	end

	task automatic send_scan(logic [11:0] h, logic [11:0] l, logic [11:0] t,
		logic fp, logic ap, logic fl);
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {1'b0, fl, ap, fp, t, l, h};
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
		board.note_scan({1'b0, fl, ap, fp, t, l, h});
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_level(logic [1:0] idx, logic [6:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_we <= 1;
		@(posedge clk);
		cfg_we <= 0;
		board.lvl[idx] = v;
		@(posedge clk);
	endtask

	task automatic random_scan();
		int unsigned m;
		logic [11:0] h, l;
		m = $urandom_range(0, 3);
		// mostly samples near the calibration ranges so hysteresis moves
		h = (m == 0) ? 12'($urandom) : 12'($urandom_range(3200, 3800));
		l = (m == 1) ? 12'($urandom) : 12'($urandom_range(200, 2800));
		send_scan(h, l, 12'($urandom), $urandom_range(0, 5) == 0,
			$urandom_range(0, 3) != 0, $urandom_range(0, 5) == 0);
	endtask

	initial begin
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// extremes, ramps through the hysteresis bands, all switch combinations
		send_scan(12'd0, 12'd0, 12'd0, 0, 1, 0);
		send_scan(12'hfff, 12'hfff, 12'hfff, 0, 1, 0);
		for (int i = 0; i < 8; i++) send_scan(12'hfff, 12'hfff, 12'hfff, i[0], i[1], i[2]);
		for (int i = 0; i < 10; i++)
			send_scan(12'(3300 + 40 * i), 12'(300 + 240 * i), 12'(410 * i), 0, 1, 0);
		send_scan(12'd3300, 12'd300, 12'd4095, 0, 0, 0);
		send_scan(12'd3700, 12'd2700, 12'd0, 1, 0, 1);
		drain();

		// equal on and off levels, then extremes of the register range
		write_level(REG_PUMP_ON, 7'd50);
		write_level(REG_PUMP_OFF, 7'd50);
		write_level(REG_LAMP_ON, 7'd50);
		write_level(REG_LAMP_OFF, 7'd50);
		for (int i = 0; i < 100; i++) random_scan();
		drain();
		write_level(REG_PUMP_ON, 7'd127);
		write_level(REG_PUMP_OFF, 7'd0);
		write_level(REG_LAMP_ON, 7'd0);
		write_level(REG_LAMP_OFF, 7'd127);
		for (int i = 0; i < 100; i++) random_scan();
		drain();
		write_level(REG_PUMP_ON, 7'($urandom_range(10, 40)));
		write_level(REG_PUMP_OFF, 7'($urandom_range(50, 90)));
		write_level(REG_LAMP_ON, 7'($urandom_range(10, 40)));
		write_level(REG_LAMP_OFF, 7'($urandom_range(50, 90)));
		for (int i = 0; i < 200; i++) random_scan();
		quiet_tail = 1;
		for (int i = 0; i < 30; i++) random_scan();
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("[plant_sensor_hysteresis_controller_unit] OK");
		else
			$display("[plant_sensor_hysteresis_controller_unit] ERROR");
		$finish;
	end
endmodule
